[hw/rtl/tmw_pkg.sv]
// Shared constants for the trimmed-mean window filter.
package tmw_pkg;
    localparam int WIN_LEN     = 8;
    localparam int SAMPLE_W    = 16;
    localparam int CNT_W       = $clog2(WIN_LEN + 1);
    localparam int STEP_W      = $clog2(WIN_LEN);
    localparam int SUM_W       = SAMPLE_W + $clog2(WIN_LEN);
    localparam int BIT_CNT_W   = $clog2(SUM_W + 1);
endpackage

[hw/rtl/tmw_stream_if.sv]
// Valid/ready stream interfaces for the sample input and the filtered output.
interface tmw_sample_if;
    import tmw_pkg::*;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface tmw_filtered_if;
    import tmw_pkg::*;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] filtered;
    modport source (output valid, output filtered, input ready);
    modport sink (input valid, input filtered, output ready);
endinterface

[hw/rtl/tmw_cell.sv]
// One window cell: holds a sample and passes it to its neighbor on shift.
module tmw_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_shift,
    input  logic [tmw_pkg::SAMPLE_W-1:0] i_d,
    output logic [tmw_pkg::SAMPLE_W-1:0] o_q
);
    import tmw_pkg::*;

    logic [SAMPLE_W-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
        end else if (i_shift) begin
            r_value <= i_d;
        end
    end

    assign o_q = r_value;
endmodule

[hw/rtl/tmw_div.sv]
// Restoring divider, one quotient bit per cycle.
module tmw_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [tmw_pkg::SUM_W-1:0]    i_dividend,
    input  logic [tmw_pkg::CNT_W-1:0]    i_divisor,
    output logic                         o_done,
    output logic [tmw_pkg::SAMPLE_W-1:0] o_quotient
);
    import tmw_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [BIT_CNT_W-1:0] r_bits;
    logic [CNT_W-1:0]     r_divisor;
    logic [CNT_W-1:0]     r_rem;
    logic [SUM_W-1:0]     r_quo;
    logic [CNT_W:0]       w_trial;
    logic                 w_fit;

    assign w_trial = {r_rem, r_quo[SUM_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_divisor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_bits <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy    <= 1'b1;
                r_bits    <= '0;
                r_divisor <= i_divisor;
                r_rem     <= '0;
                r_quo     <= i_dividend;
            end else if (r_busy) begin
                r_rem  <= w_fit ? CNT_W'(w_trial - {1'b0, r_divisor}) : w_trial[CNT_W-1:0];
                r_quo  <= {r_quo[SUM_W-2:0], w_fit};
                r_bits <= r_bits + 1'b1;
                if (r_bits == BIT_CNT_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo[SAMPLE_W-1:0];
endmodule

[hw/rtl/trimmed_mean_window_u16.sv]
// Trimmed-mean moving-average filter over a ring of window cells.
//
//   port        | dir | payload            | transfer when
//   i_sample    | in  | sample   [15:0]    | valid && ready
//   o_filtered  | out | filtered [15:0]    | valid && ready
//
// Each item takes a full rotation of the cell ring to sum and find the
// extremes, then one divider cycle per dividend bit. A new sample is taken
// once the previous result has moved to the output register. A stalled
// output holds its value; the next item then waits at the end of its
// divide. Reset clears the window to zero, the fill count and all handshake
// state.
module trimmed_mean_window_u16 (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tmw_sample_if.sink     i_sample,
    tmw_filtered_if.source o_filtered
);
    import tmw_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CALC,
        S_DIV,
        S_OUT
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_count;
    logic [STEP_W-1:0]   r_step;
    logic [SUM_W-1:0]    r_sum;
    logic [SAMPLE_W-1:0] r_hi;
    logic [SAMPLE_W-1:0] r_lo;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_data;

    logic [SAMPLE_W-1:0] w_q [WIN_LEN];
    logic                w_accept;
    logic                w_shift;
    logic [SAMPLE_W-1:0] w_tail;
    logic                w_full;
    logic                w_div_start;
    logic [SUM_W-1:0]    w_dividend;
    logic [CNT_W-1:0]    w_divisor;
    logic                w_div_done;
    logic [SAMPLE_W-1:0] w_quotient;
    logic                w_out_free;

    assign i_sample.ready = (r_state == S_IDLE);
    assign w_accept       = i_sample.valid && i_sample.ready;
    assign w_shift        = w_accept || (r_state == S_SCAN);
    assign w_tail         = w_q[WIN_LEN-1];
    assign w_full         = (r_count == CNT_W'(WIN_LEN));
    assign w_div_start    = (r_state == S_CALC);
    assign w_dividend     = w_full ? (r_sum - SUM_W'(r_hi) - SUM_W'(r_lo)) : r_sum;
    assign w_divisor      = w_full ? CNT_W'(WIN_LEN - 2) : r_count;
    assign w_out_free     = !r_out_valid || o_filtered.ready;

    for (genvar k = 0; k < WIN_LEN; k++) begin : g_cell
        logic [SAMPLE_W-1:0] w_d;
        if (k == 0) begin : g_head
            assign w_d = (r_state == S_IDLE) ? i_sample.sample : w_tail;
        end else begin : g_body
            assign w_d = w_q[k-1];
        end
        tmw_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_d     (w_d),
            .o_q     (w_q[k])
        );
    end

    tmw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_filtered.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (!w_full) begin
                            r_count <= r_count + 1'b1;
                        end
                        r_step  <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_step == '0) begin
                        r_sum <= SUM_W'(w_tail);
                        r_hi  <= w_tail;
                        r_lo  <= w_tail;
                    end else begin
                        r_sum <= r_sum + SUM_W'(w_tail);
                        if (w_tail > r_hi) begin
                            r_hi <= w_tail;
                        end
                        if (w_tail < r_lo) begin
                            r_lo <= w_tail;
                        end
                    end
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(WIN_LEN - 1)) begin
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= w_quotient;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_filtered.valid    = r_out_valid;
    assign o_filtered.filtered = r_out_data;
endmodule

[hw/rtl/tmw_chk.sv]
// Port-level checks for the trimmed-mean window filter, bound to the top level.
module tmw_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [tmw_pkg::SAMPLE_W-1:0] i_out_data
);
    import tmw_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled output changed");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while an item is in work");

    a_no_fast_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid) ##1 !$rose(i_out_valid))
        else $error("result appeared too soon after input transfer");

    a_ready_idle_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> i_in_ready)
        else $error("result delivered without returning to idle");
endmodule

bind trimmed_mean_window_u16 tmw_chk u_tmw_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample.valid),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_filtered.valid),
    .i_out_ready (o_filtered.ready),
    .i_out_data  (o_filtered.filtered)
);

[dv/tb_trimmed_mean_window_u16.sv]
// Testbench for trimmed_mean_window_u16: directed and random sample streams checked by a scoreboard.
class trim_mean_board;
    logic [tmw_pkg::SAMPLE_W-1:0] cells [tmw_pkg::WIN_LEN];
    int unsigned                  wr_pos;
    bit                           full;
    logic [tmw_pkg::SAMPLE_W-1:0] pending_means [$];
    int unsigned                  errors;
    int unsigned                  checked;
    int unsigned                  taken;

    function new();
        foreach (cells[i]) cells[i] = '0;
        wr_pos  = 0;
        full    = 1'b0;
        errors  = 0;
        checked = 0;
        taken   = 0;
    endfunction

    function void take_sample(logic [tmw_pkg::SAMPLE_W-1:0] s);
        int unsigned sum;
        int unsigned hi;
        int unsigned lo;
        int unsigned count;
        int unsigned mean;
        cells[wr_pos] = s;
        wr_pos++;
        count = wr_pos;
        sum   = 0;
        hi    = cells[0];
        lo    = cells[0];
        foreach (cells[i]) begin
            sum += cells[i];
            if (cells[i] > hi) hi = cells[i];
            if (cells[i] < lo) lo = cells[i];
        end
        if (wr_pos == tmw_pkg::WIN_LEN) begin
            wr_pos = 0;
            full   = 1'b1;
        end
        if (full) begin
            mean = (sum - hi - lo) / (tmw_pkg::WIN_LEN - 2);
        end else begin
            mean = sum / count;
        end
        pending_means.push_back(mean[tmw_pkg::SAMPLE_W-1:0]);
        taken++;
    endfunction

    function void check_filtered(logic [tmw_pkg::SAMPLE_W-1:0] got);
        logic [tmw_pkg::SAMPLE_W-1:0] want;
        if (pending_means.size() == 0) begin
            errors++;
            $display("%0t: filtered result %0d with no sample pending", $time, got);
        end else begin
            want = pending_means.pop_front();
            checked++;
            if (got !== want) begin
                errors++;
                $display("%0t: filtered mismatch, expected %0d actual %0d", $time, want, got);
            end
        end
    endfunction
endclass

module tb_trimmed_mean_window_u16;
    import tmw_pkg::*;

    localparam int NUM_DIRECTED = 24;
    localparam int NUM_RANDOM   = 1150;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    tmw_sample_if   smp_if();
    tmw_filtered_if flt_if();

    trimmed_mean_window_u16 i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (smp_if),
        .o_filtered (flt_if)
    );

    trim_mean_board board;

    logic [SAMPLE_W-1:0] directed_samples [NUM_DIRECTED] = '{
        16'hFFFF, 16'hFFFF, 16'h0000, 16'h0001, 16'hFFFF, 16'h0002, 16'h0003, 16'hFFFF,
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF
    };

    logic [SAMPLE_W-1:0] last_sample;
    int unsigned         cycles;
    int unsigned         stall_cycles;
    int unsigned         rx_phase;
    int unsigned         rx_mode;
    logic [15:0]         rx_pattern;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("tb_trimmed_mean_window_u16: done, errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            flt_if.ready <= 1'b0;
            rx_phase     <= 0;
            rx_mode      <= 0;
            rx_pattern   <= 16'hFFFF;
        end else begin
            rx_phase <= rx_phase + 1;
            if (rx_phase % 128 == 0) begin
                rx_mode    <= $urandom_range(0, 3);
                rx_pattern <= $urandom;
            end
            case (rx_mode)
                0: flt_if.ready <= 1'b1;
                1: flt_if.ready <= rx_pattern[rx_phase % 16];
                2: flt_if.ready <= ($urandom_range(0, 3) == 0);
                default: flt_if.ready <= (rx_phase % 16 == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (smp_if.valid && smp_if.ready) board.take_sample(smp_if.sample);
            if (flt_if.valid && flt_if.ready) board.check_filtered(flt_if.filtered);
            if (flt_if.valid && !flt_if.ready) stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic [SAMPLE_W-1:0] pick_sample(logic [SAMPLE_W-1:0] prev);
        logic [SAMPLE_W-1:0] v;
        case ($urandom_range(0, 6))
            0: v = $urandom_range(0, 15);
            1: v = $urandom_range(65520, 65535);
            2: v = prev + $urandom_range(0, 64) - 32;
            3: v = prev;
            4: v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] v);
        smp_if.valid  <= 1'b1;
        smp_if.sample <= v;
        do @(posedge i_clk); while (!smp_if.ready);
    endtask

    task automatic idle_sender(input int unsigned n);
        smp_if.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    initial begin
        int unsigned         idx;
        int unsigned         burst_left;
        logic [SAMPLE_W-1:0] v;
        board         = new();
        cycles        = 0;
        stall_cycles  = 0;
        last_sample   = '0;
        smp_if.valid  <= 1'b0;
        smp_if.sample <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        burst_left = $urandom_range(1, 12);
        for (idx = 0; idx < NUM_DIRECTED + NUM_RANDOM; idx++) begin
            if (idx < NUM_DIRECTED) v = directed_samples[idx];
            else v = pick_sample(last_sample);
            last_sample = v;
            send_sample(v);
            burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 40));
            end
        end
        smp_if.valid <= 1'b0;

        while (board.pending_means.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d samples (%0d directed), checked %0d filtered results, %0d stalls.",
                 board.taken, NUM_DIRECTED, board.checked, stall_cycles);
        if (board.errors == 0 && board.pending_means.size() == 0) begin
            $display("tb_trimmed_mean_window_u16: done, clean");
        end else begin
            $display("tb_trimmed_mean_window_u16: done, errors");
        end
        $finish;
    end
endmodule
